/* hdl/aprt_pkg.sv */
// Package for the age-by-period rate table: field widths, command, status,
// register and state codes, parameter defaults and the span helper.
// No dependencies.
package aprt_pkg;

   localparam int MAX_YEARS_DEF   = 64;
   localparam int MAX_AGES_DEF    = 128;
   localparam int COUNT_WIDTH_DEF = 24;

   localparam int TIME_W      = 16;
   localparam int AGE_IDX_W   = 7;
   localparam int YEAR_IDX_W  = 6;
   localparam int CELLS_W     = 7;
   localparam int SUM_W       = 32;
   localparam int RATE_W      = 14;
   localparam int RADIUS_W    = 3;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [RATE_W-1:0] RATE_SCALE = 14'd10000;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_BAD_CASE = 2'd1,
      STAT_OUTSIDE  = 2'd2
   } status_type;

   localparam logic [CSR_IDX_W-1:0] REG_YEAR_LO = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_YEAR_HI = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_AGE_LO  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_AGE_HI  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RADIUS  = 3'd4;

   localparam logic [TIME_W-1:0]   YEAR_LO_RST = 16'd0;
   localparam logic [TIME_W-1:0]   YEAR_HI_RST = 16'd63;
   localparam logic [TIME_W-1:0]   AGE_LO_RST  = 16'd0;
   localparam logic [TIME_W-1:0]   AGE_HI_RST  = 16'd127;
   localparam logic [RADIUS_W-1:0] RADIUS_RST  = 3'd0;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD_PREP,
      ST_ADD_SETUP,
      ST_ADD_WALK,
      ST_ADD_DRAIN,
      ST_QRY_CHECK,
      ST_QRY_WALK,
      ST_QRY_DRAIN,
      ST_QRY_MUL,
      ST_QRY_DIVCHK,
      ST_QRY_DIV,
      ST_DONE
   } state_type;

   // rows or columns in use: hi - lo + 1 clipped to cap, zero when hi < lo
   function automatic logic [16:0] span_f(input logic [TIME_W-1:0] lo,
                                          input logic [TIME_W-1:0] hi,
                                          input logic [16:0] cap);
      logic [16:0] n;
      n = 17'(hi) - 17'(lo) + 17'd1;
      if (hi < lo) begin
         return 17'd0;
      end
      return (n > cap) ? cap : n;
   endfunction

endpackage

/* hdl/age_period_rate_table.sv */
// Age-by-period exposure table with windowed rate query, built around two
// single-port-write / registered-read count memories.
// Depends on aprt_pkg.
//
// One item at a time: start is taken while busy is low, and the result shows on
// the rsp_ ports for exactly one cycle with rsp_strobe high; the receiver cannot
// stall it, so it must take it then. An add walks the years from entry to exit
// that fall in the table, one memory read-modify-write per cycle (pipelined over
// the registered read). A query reads (2*radius+1)^2 window cells, one per
// cycle, then a multiply and a 14-step shift-subtract divider. A clear zeroes
// one memory address per cycle, all 2^(clog2(MAX_AGES)+clog2(MAX_YEARS)) of them
// (8192 at the defaults), with busy high throughout; the clearing pass right
// after reset also runs with busy high and gives no result. Register writes on
// the csr_ port are taken at any time but should only be made while busy is low.
module age_period_rate_table
   import aprt_pkg::*;
#(
   parameter int MAX_YEARS   = MAX_YEARS_DEF,
   parameter int MAX_AGES    = MAX_AGES_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_cmd,
   input  logic [TIME_W-1:0]      req_start_time,
   input  logic [TIME_W-1:0]      req_entry_time,
   input  logic [TIME_W-1:0]      req_exit_time,
   input  logic                   req_event_flag,
   input  logic [AGE_IDX_W-1:0]   req_age_index,
   input  logic [YEAR_IDX_W-1:0]  req_year_index,

   output logic                   rsp_strobe,
   output logic [1:0]             rsp_status,
   output logic [CELLS_W-1:0]     rsp_cells_added,
   output logic                   rsp_events_added,
   output logic [SUM_W-1:0]       rsp_risk_sum,
   output logic [SUM_W-1:0]       rsp_event_sum,
   output logic [RATE_W-1:0]      rsp_rate_centi,
   output logic                   rsp_rate_valid,

   input  logic                   csr_write,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int AW     = (MAX_AGES > 1) ? $clog2(MAX_AGES) : 1;
   localparam int YW     = (MAX_YEARS > 1) ? $clog2(MAX_YEARS) : 1;
   localparam int ADDR_W = AW + YW;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int NAW    = $clog2(MAX_AGES + 1);
   localparam int NYW    = $clog2(MAX_YEARS + 1);
   localparam int NMAX_W = (NAW > NYW) ? NAW : NYW;
   localparam int SW     = ((NMAX_W > 8) ? NMAX_W : 8) + 2;
   localparam int CW     = COUNT_WIDTH;
   localparam int NUM_W  = SUM_W + RATE_W;
   localparam int STEP_W = $clog2(RATE_W);

   function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   // configuration
   logic [TIME_W-1:0]   year_lo_ff, year_hi_ff, age_lo_ff, age_hi_ff;
   logic [RADIUS_W-1:0] radius_ff;
   logic [16:0]         na_full, ny_full;
   logic [NAW-1:0]      na_ff;
   logic [NYW-1:0]      ny_ff;

   // control
   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   clr_addr_ff;
   logic                clr_reply_ff;
   logic                pv_ff, pv_in;

   // latched item
   logic [TIME_W-1:0]   ts_ff, tc_ff, tf_ff;
   logic                ev_ff;
   logic [AGE_IDX_W-1:0]  ai_ff;
   logic [YEAR_IDX_W-1:0] yi_ff;

   // add walk
   logic [TIME_W-1:0]   j_ff, hi_ff;
   logic [16:0]         tsage_ff;
   logic [16:0]         ylast;
   logic [YW-1:0]       t_ff;
   logic signed [17:0]  aoff_ff;
   logic                bad_case, in_rng;

   // query walk
   logic signed [3:0]    di_ff, dj_ff, r_s, neg_r;
   logic signed [SW-1:0] sa, sy, na_s, ny_s, qa_full, qt_full;
   logic [AW-1:0]        qa;
   logic [YW-1:0]        qt;
   logic                 outside, win_last;

   // memories
   logic [CW-1:0]       risk_mem  [DEPTH];
   logic [CW-1:0]       event_mem [DEPTH];
   logic [CW-1:0]       rd_risk_ff, rd_event_ff;
   logic [ADDR_W-1:0]   rd_addr, wr_addr, p_addr_ff;
   logic                p_ev_ff;
   logic                risk_we, event_we;
   logic [CW-1:0]       risk_wd, event_wd;

   // sums and divider
   logic [32:0]         rs_sum, es_sum;
   logic [SUM_W-1:0]    rs_ff, es_ff;
   logic [NUM_W-1:0]    num_ff;
   logic [SUM_W-1:0]    rem_ff;
   logic [RATE_W-1:0]   nl_ff, q_ff, q_next;
   logic [STEP_W-1:0]   step_ff;
   logic [32:0]         trial, trial_sub;
   logic                ge;

   // result
   status_type          status_ff;
   logic [CELLS_W-1:0]  cells_ff;
   logic                events_ff;
   logic [RATE_W-1:0]   rate_ff;
   logic                rate_valid_ff;

   // ---------------- configuration registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         year_lo_ff <= YEAR_LO_RST;
         year_hi_ff <= YEAR_HI_RST;
         age_lo_ff  <= AGE_LO_RST;
         age_hi_ff  <= AGE_HI_RST;
         radius_ff  <= RADIUS_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_YEAR_LO: year_lo_ff <= csr_data;
            REG_YEAR_HI: year_hi_ff <= csr_data;
            REG_AGE_LO:  age_lo_ff  <= csr_data;
            REG_AGE_HI:  age_hi_ff  <= csr_data;
            REG_RADIUS:  radius_ff  <= csr_data[RADIUS_W-1:0];
            default: ;
         endcase
      end
   end

   assign na_full = span_f(age_lo_ff, age_hi_ff, 17'(MAX_AGES));
   assign ny_full = span_f(year_lo_ff, year_hi_ff, 17'(MAX_YEARS));

   always_ff @(posedge clock) begin
      na_ff <= na_full[NAW-1:0];
      ny_ff <= ny_full[NYW-1:0];
   end

   // ---------------- datapath decode ----------------
   assign bad_case = (ts_ff > tc_ff) || (tc_ff > tf_ff);
   assign ylast    = 17'(year_lo_ff) + 17'(ny_ff) - 17'd1;
   assign in_rng   = !aoff_ff[17] && (aoff_ff[16:0] < 17'(na_ff));

   assign r_s      = $signed({1'b0, radius_ff});
   assign neg_r    = 4'sd0 - r_s;
   assign win_last = (di_ff == r_s) && (dj_ff == r_s);
   assign outside  = (17'(ai_ff) >= 17'(na_ff)) || (17'(yi_ff) >= 17'(ny_ff));

   // window indices clamped to the table edges
   assign na_s = SW'(na_ff);
   assign ny_s = SW'(ny_ff);
   assign sa   = SW'($signed({1'b0, ai_ff})) + SW'(di_ff);
   assign sy   = SW'($signed({1'b0, yi_ff})) + SW'(dj_ff);

   always_comb begin
      if (sa[SW-1]) begin
         qa_full = '0;
      end else if (sa >= na_s) begin
         qa_full = na_s - SW'(1);
      end else begin
         qa_full = sa;
      end
      if (sy[SW-1]) begin
         qt_full = '0;
      end else if (sy >= ny_s) begin
         qt_full = ny_s - SW'(1);
      end else begin
         qt_full = sy;
      end
   end

   assign qa = qa_full[AW-1:0];
   assign qt = qt_full[YW-1:0];

   assign rs_sum = {1'b0, rs_ff} + 33'(rd_risk_ff);
   assign es_sum = {1'b0, es_ff} + 33'(rd_event_ff);

   assign trial     = {rem_ff, nl_ff[RATE_W-1]};
   assign ge        = trial >= {1'b0, rs_ff};
   assign trial_sub = trial - {1'b0, rs_ff};
   assign q_next    = {q_ff[RATE_W-2:0], ge};

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (&clr_addr_ff) begin
               state_in = clr_reply_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               unique case (cmd_type'(req_cmd))
                  CMD_CLEAR: state_in = ST_CLEAR;
                  CMD_ADD:   state_in = ST_ADD_PREP;
                  CMD_QUERY: state_in = ST_QRY_CHECK;
                  CMD_NOP:   state_in = ST_DONE;
               endcase
            end
         end
         ST_ADD_PREP: begin
            if (bad_case || (ny_ff == '0) || (na_ff == '0)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_ADD_SETUP;
            end
         end
         ST_ADD_SETUP: state_in = (j_ff > hi_ff) ? ST_DONE : ST_ADD_WALK;
         ST_ADD_WALK: begin
            if (j_ff == hi_ff) begin
               state_in = ST_ADD_DRAIN;
            end
         end
         ST_ADD_DRAIN:  state_in = ST_DONE;
         ST_QRY_CHECK:  state_in = outside ? ST_DONE : ST_QRY_WALK;
         ST_QRY_WALK: begin
            if (win_last) begin
               state_in = ST_QRY_DRAIN;
            end
         end
         ST_QRY_DRAIN:  state_in = ST_QRY_MUL;
         ST_QRY_MUL:    state_in = (rs_ff == '0) ? ST_DONE : ST_QRY_DIVCHK;
         ST_QRY_DIVCHK: begin
            if (num_ff[NUM_W-1:RATE_W] >= rs_ff) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_QRY_DIV;
            end
         end
         ST_QRY_DIV: begin
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- outputs and memory control ----------------
   always_comb begin
      busy       = (state_ff != ST_IDLE);
      rsp_strobe = (state_ff == ST_DONE);
      rd_addr    = '0;
      wr_addr    = p_addr_ff;
      risk_we    = 1'b0;
      event_we   = 1'b0;
      risk_wd    = sat_inc(rd_risk_ff);
      event_wd   = sat_inc(rd_event_ff);
      pv_in      = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_addr  = clr_addr_ff;
            risk_we  = 1'b1;
            event_we = 1'b1;
            risk_wd  = '0;
            event_wd = '0;
         end
         ST_ADD_WALK: begin
            rd_addr  = {aoff_ff[AW-1:0], t_ff};
            pv_in    = in_rng;
            risk_we  = pv_ff;
            event_we = pv_ff && p_ev_ff;
         end
         ST_ADD_DRAIN: begin
            risk_we  = pv_ff;
            event_we = pv_ff && p_ev_ff;
         end
         ST_QRY_WALK: begin
            rd_addr = {qa, qt};
            pv_in   = 1'b1;
         end
         default: ;
      endcase
   end

   // ---------------- memories ----------------
   always_ff @(posedge clock) begin
      if (risk_we) begin
         risk_mem[wr_addr] <= risk_wd;
      end
      rd_risk_ff <= risk_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (event_we) begin
         event_mem[wr_addr] <= event_wd;
      end
      rd_event_ff <= event_mem[rd_addr];
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         clr_reply_ff <= 1'b0;
         pv_ff        <= 1'b0;
      end else begin
         state_ff <= state_in;
         pv_ff    <= pv_in;
         if (state_ff == ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         // the sweep after reset answers nothing, a clear item does
         if ((state_ff == ST_IDLE) && start) begin
            clr_reply_ff <= 1'b1;
         end
      end
   end

   // ---------------- datapath registers ----------------
   always_ff @(posedge clock) begin
      p_addr_ff <= rd_addr;
      p_ev_ff   <= ev_ff && (j_ff == tf_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ts_ff         <= req_start_time;
               tc_ff         <= req_entry_time;
               tf_ff         <= req_exit_time;
               ev_ff         <= req_event_flag;
               ai_ff         <= req_age_index;
               yi_ff         <= req_year_index;
               status_ff     <= STAT_OK;
               cells_ff      <= '0;
               events_ff     <= 1'b0;
               rs_ff         <= '0;
               es_ff         <= '0;
               rate_ff       <= '0;
               rate_valid_ff <= 1'b0;
            end
         end
         ST_ADD_PREP: begin
            j_ff     <= (tc_ff > year_lo_ff) ? tc_ff : year_lo_ff;
            hi_ff    <= (ylast[TIME_W-1:0] < tf_ff) ? ylast[TIME_W-1:0] : tf_ff;
            tsage_ff <= 17'(ts_ff) + 17'(age_lo_ff);
            if (bad_case) begin
               status_ff <= STAT_BAD_CASE;
            end
         end
         ST_ADD_SETUP: begin
            t_ff    <= YW'(j_ff - year_lo_ff);
            aoff_ff <= $signed(18'(j_ff)) - $signed(18'(tsage_ff));
         end
         ST_ADD_WALK: begin
            j_ff    <= j_ff + 1'b1;
            t_ff    <= t_ff + 1'b1;
            aoff_ff <= aoff_ff + 18'sd1;
            if (in_rng) begin
               if (!(&cells_ff)) begin
                  cells_ff <= cells_ff + 1'b1;
               end
               if (ev_ff && (j_ff == tf_ff)) begin
                  events_ff <= 1'b1;
               end
            end
         end
         ST_QRY_CHECK: begin
            di_ff <= neg_r;
            dj_ff <= neg_r;
            if (outside) begin
               status_ff <= STAT_OUTSIDE;
            end
         end
         ST_QRY_WALK: begin
            if (dj_ff == r_s) begin
               dj_ff <= neg_r;
               di_ff <= di_ff + 4'sd1;
            end else begin
               dj_ff <= dj_ff + 4'sd1;
            end
            if (pv_ff) begin
               rs_ff <= rs_sum[32] ? '1 : rs_sum[SUM_W-1:0];
               es_ff <= es_sum[32] ? '1 : es_sum[SUM_W-1:0];
            end
         end
         ST_QRY_DRAIN: begin
            if (pv_ff) begin
               rs_ff <= rs_sum[32] ? '1 : rs_sum[SUM_W-1:0];
               es_ff <= es_sum[32] ? '1 : es_sum[SUM_W-1:0];
            end
         end
         ST_QRY_MUL: begin
            num_ff        <= es_ff * RATE_SCALE;
            rate_valid_ff <= (rs_ff != '0);
         end
         ST_QRY_DIVCHK: begin
            // quotient of 2^14 or more would be clipped anyway
            if (num_ff[NUM_W-1:RATE_W] >= rs_ff) begin
               rate_ff <= RATE_SCALE;
            end else begin
               rem_ff  <= num_ff[NUM_W-1:RATE_W];
               nl_ff   <= num_ff[RATE_W-1:0];
               q_ff    <= '0;
               step_ff <= STEP_W'(RATE_W - 1);
            end
         end
         ST_QRY_DIV: begin
            rem_ff  <= ge ? trial_sub[SUM_W-1:0] : trial[SUM_W-1:0];
            nl_ff   <= {nl_ff[RATE_W-2:0], 1'b0};
            q_ff    <= q_next;
            step_ff <= step_ff - 1'b1;
            if (step_ff == '0) begin
               rate_ff <= (q_next > RATE_SCALE) ? RATE_SCALE : q_next;
            end
         end
         default: ;
      endcase
   end

   assign rsp_status       = status_ff;
   assign rsp_cells_added  = cells_ff;
   assign rsp_events_added = events_ff;
   assign rsp_risk_sum     = rs_ff;
   assign rsp_event_sum    = es_ff;
   assign rsp_rate_centi   = rate_ff;
   assign rsp_rate_valid   = rate_valid_ff;

endmodule
